/* rtl/core/ados_pkg.sv */
// Shared types and constants of the ADC oversampling decimator.
package ados_pkg;

  localparam int CHANNELS      = 8;
  localparam int WARMUP_EVENTS = 10;
  localparam int SAMPLE_BITS   = 12;

  localparam int ACC_W      = 32;
  localparam int DIV_W      = 16;
  localparam int VAL_W      = 16;
  localparam int POS_W      = 17;
  localparam int IDX_W      = 16;
  localparam int OSC_W      = 9;
  localparam int ACT_W      = 4;
  localparam int CH_W       = 3;
  localparam int NCH_W      = $clog2(CHANNELS + 1);
  localparam int LANE_W     = $clog2(CHANNELS);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_STEPS  = ACC_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_CHANNELS,
    REG_OVERSAMPLE_COUNT,
    REG_OVERSAMPLE_DIVIDER,
    REG_CAPTURE_LENGTH,
    REG_CONTINUOUS_MODE
  } cfg_reg_t;

  typedef struct packed {
    logic                          req_type;
    logic                          seq_end_flag;
    logic signed [SAMPLE_BITS-1:0] sample_0;
    logic signed [SAMPLE_BITS-1:0] sample_1;
    logic signed [SAMPLE_BITS-1:0] sample_2;
    logic signed [SAMPLE_BITS-1:0] sample_3;
    logic signed [SAMPLE_BITS-1:0] sample_4;
    logic signed [SAMPLE_BITS-1:0] sample_5;
    logic signed [SAMPLE_BITS-1:0] sample_6;
    logic signed [SAMPLE_BITS-1:0] sample_7;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]         channel_index;
    logic [IDX_W-1:0]        sample_index;
    logic signed [VAL_W-1:0] sample_value;
    logic                    last_of_run;
    logic                    capture_done;
  } out_item_t;

  typedef struct packed {
    logic acc_en;
    logic load;
    logic div_start;
    logic div_step;
  } lane_ctrl_t;

  typedef struct packed {
    logic             start;
    logic [NCH_W-1:0] nch;
    logic [IDX_W-1:0] pos;
    logic             done;
  } emit_t;

endpackage

/* rtl/core/ados_lane.sv */
// One channel lane: accumulator and bit-serial restoring divider.
module ados_lane (
  input  logic                                    clk,
  input  ados_pkg::lane_ctrl_t                    ctrl,
  input  logic signed [ados_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [ados_pkg::DIV_W-1:0]              divisor,
  output logic signed [ados_pkg::VAL_W-1:0]       quotient
);

  logic [ados_pkg::ACC_W-1:0] acc_r;
  logic [ados_pkg::ACC_W-1:0] mag_r;
  logic [ados_pkg::DIV_W-1:0] rem_r;
  logic                       neg_r;

  logic [ados_pkg::ACC_W-1:0] sample_ext;
  logic [ados_pkg::DIV_W:0]   rem_sh;
  logic [ados_pkg::DIV_W:0]   rem_diff;
  logic                       rem_ge;

  assign sample_ext = {{(ados_pkg::ACC_W - ados_pkg::SAMPLE_BITS){sample[ados_pkg::SAMPLE_BITS-1]}},
                       sample};

  assign rem_sh   = {rem_r, mag_r[ados_pkg::ACC_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, divisor};
  assign rem_diff = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (ctrl.acc_en) begin
      acc_r <= ctrl.load ? sample_ext : acc_r + sample_ext;
    end
    if (ctrl.div_start) begin
      neg_r <= acc_r[ados_pkg::ACC_W-1];
      mag_r <= acc_r[ados_pkg::ACC_W-1] ? (~acc_r + 1'b1) : acc_r;
      rem_r <= '0;
    end else if (ctrl.div_step) begin
      rem_r <= rem_ge ? rem_diff[ados_pkg::DIV_W-1:0] : rem_sh[ados_pkg::DIV_W-1:0];
      mag_r <= {mag_r[ados_pkg::ACC_W-2:0], rem_ge};
    end
  end

  // Negate and wrap the quotient back to the result width.
  assign quotient = neg_r ? (~mag_r[ados_pkg::VAL_W-1:0] + 1'b1) : mag_r[ados_pkg::VAL_W-1:0];

endmodule

/* rtl/core/ados_merge.sv */
// Merge stage: walks the lane quotients in channel order into the output register.
module ados_merge (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ados_pkg::emit_t                     emit,
  input  logic signed [ados_pkg::VAL_W-1:0]   quot [ados_pkg::CHANNELS],
  input  logic                                out_ready,
  output logic                                out_valid,
  output ados_pkg::out_item_t                 out_data,
  output logic                                busy
);

  logic                         busy_r;
  logic [ados_pkg::LANE_W-1:0]  idx_r;
  logic [ados_pkg::NCH_W-1:0]   nch_r;
  logic [ados_pkg::IDX_W-1:0]   pos_r;
  logic                         done_r;
  logic                         out_valid_r;
  ados_pkg::out_item_t          out_data_r;

  logic                         issue;
  logic                         last;

  assign issue = busy_r && (!out_valid_r || out_ready);
  assign last  = (ados_pkg::NCH_W'(idx_r) + 1'b1) == nch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit.start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
        nch_r  <= emit.nch;
        pos_r  <= emit.pos;
        done_r <= emit.done;
      end else if (issue) begin
        if (last) begin
          busy_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
      if (issue) begin
        out_valid_r                <= 1'b1;
        out_data_r.channel_index   <= ados_pkg::CH_W'(idx_r);
        out_data_r.sample_index    <= pos_r;
        out_data_r.sample_value    <= quot[idx_r];
        out_data_r.last_of_run     <= last;
        out_data_r.capture_done    <= done_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/adc_oversample_decimator_core.sv */
// Top level: capture control, channel lanes and result merge of the decimator.
// An event that closes an oversampling group passes through a load state, the divide
// run (one quotient bit per cycle in every lane at once) and a hand-off state; then
// results leave at one per cycle unless out_ready holds the output register.
// Throughput: after a closing event the input stays shut until the last result has
// been issued to the output register; other items are taken at one per cycle.
// Reset (synchronous, rst_n low) clears control state and restores register defaults;
// the channel accumulators are not cleared and need no clearing pass.
module adc_oversample_decimator_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ados_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ados_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [ados_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [ados_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_EMIT,
    ST_DRAIN
  } state_t;

  // Configuration registers.
  logic [ados_pkg::ACT_W-1:0]       act_r;
  logic [ados_pkg::OSC_W-1:0]       osc_cfg_r;
  logic [ados_pkg::DIV_W-1:0]       div_cfg_r;
  logic [ados_pkg::IDX_W-1:0]       len_r;
  logic                             cont_r;

  // Capture control state.
  state_t                           state_r, state_nxt;
  logic signed [ados_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [ados_pkg::OSC_W-1:0]       osc_r, osc_nxt;
  logic                             armed_r, armed_nxt;
  logic [ados_pkg::STEP_W-1:0]      step_r, step_nxt;
  logic [ados_pkg::NCH_W-1:0]       emit_nch_r;
  logic [ados_pkg::IDX_W-1:0]       emit_pos_r;
  logic                             emit_done_r;

  logic                             in_fire;
  logic                             acc_fire;
  logic                             emit_fire;
  logic [ados_pkg::NCH_W-1:0]       nch;
  logic [ados_pkg::OSC_W-1:0]       osc_inc;
  logic [ados_pkg::OSC_W-1:0]       osc_eff;
  logic [ados_pkg::DIV_W-1:0]       divisor;
  logic signed [ados_pkg::POS_W-1:0] len_s;
  logic signed [ados_pkg::POS_W-1:0] pos_inc;
  logic                             merge_busy;
  ados_pkg::emit_t                  emit;

  logic signed [ados_pkg::SAMPLE_BITS-1:0] samples [ados_pkg::CHANNELS];
  logic signed [ados_pkg::VAL_W-1:0]       quot    [ados_pkg::CHANNELS];
  ados_pkg::lane_ctrl_t                    lane_ctrl [ados_pkg::CHANNELS];

  assign in_ready = (state_r == ST_IDLE) && !merge_busy;
  assign in_fire  = in_valid && in_ready;

  // Clamp channel count; zero oversample count and zero divider act as one.
  assign nch     = (act_r > ados_pkg::ACT_W'(ados_pkg::CHANNELS))
                   ? ados_pkg::NCH_W'(ados_pkg::CHANNELS) : ados_pkg::NCH_W'(act_r);
  assign osc_eff = (osc_cfg_r == '0) ? ados_pkg::OSC_W'(1) : osc_cfg_r;
  assign divisor = (div_cfg_r == '0) ? ados_pkg::DIV_W'(1) : div_cfg_r;
  assign len_s   = $signed({1'b0, len_r});
  assign osc_inc = osc_r + 1'b1;
  assign pos_inc = pos_r + $signed(ados_pkg::POS_W'(1));

  always_comb begin
    pos_nxt   = pos_r;
    osc_nxt   = osc_r;
    armed_nxt = armed_r;
    acc_fire  = 1'b0;
    emit_fire = 1'b0;
    if (in_fire) begin
      if (!in_data.req_type) begin
        // Start: arm and enter warm-up.
        pos_nxt   = -ados_pkg::POS_W'(ados_pkg::WARMUP_EVENTS);
        osc_nxt   = '0;
        armed_nxt = 1'b1;
      end else if (armed_r) begin
        if (pos_r >= len_s) begin
          // End of capture: restart or disarm, drop the event either way.
          if (cont_r) begin
            pos_nxt = '0;
            osc_nxt = '0;
          end else begin
            armed_nxt = 1'b0;
          end
        end else if (in_data.seq_end_flag) begin
          if (pos_r < 0) begin
            pos_nxt = pos_inc;
          end else begin
            acc_fire = 1'b1;
            if (osc_inc >= osc_eff) begin
              osc_nxt   = '0;
              emit_fire = 1'b1;
              pos_nxt   = pos_inc;
            end else begin
              osc_nxt = osc_inc;
            end
          end
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (emit_fire && (nch != '0)) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_RUN;
        step_nxt  = '0;
      end
      ST_RUN: begin
        step_nxt = step_r + 1'b1;
        if (step_r == ados_pkg::STEP_W'(ados_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!merge_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r     <= '0;
      osc_cfg_r <= ados_pkg::OSC_W'(1);
      div_cfg_r <= ados_pkg::DIV_W'(1);
      len_r     <= '0;
      cont_r    <= 1'b0;
      state_r   <= ST_IDLE;
      pos_r     <= '0;
      osc_r     <= '0;
      armed_r   <= 1'b0;
      step_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (ados_pkg::cfg_reg_t'(cfg_idx))
          ados_pkg::REG_ACTIVE_CHANNELS:    act_r     <= cfg_wdata[ados_pkg::ACT_W-1:0];
          ados_pkg::REG_OVERSAMPLE_COUNT:   osc_cfg_r <= cfg_wdata[ados_pkg::OSC_W-1:0];
          ados_pkg::REG_OVERSAMPLE_DIVIDER: div_cfg_r <= cfg_wdata[ados_pkg::DIV_W-1:0];
          ados_pkg::REG_CAPTURE_LENGTH:     len_r     <= cfg_wdata[ados_pkg::IDX_W-1:0];
          ados_pkg::REG_CONTINUOUS_MODE:    cont_r    <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      osc_r   <= osc_nxt;
      armed_r <= armed_nxt;
      step_r  <= step_nxt;
      if (emit_fire) begin
        // Hold what the merge stage tags each result with.
        emit_nch_r  <= nch;
        emit_pos_r  <= pos_r[ados_pkg::IDX_W-1:0];
        emit_done_r <= pos_inc >= len_s;
      end
    end
  end

  assign samples[0] = in_data.sample_0;
  assign samples[1] = in_data.sample_1;
  assign samples[2] = in_data.sample_2;
  assign samples[3] = in_data.sample_3;
  assign samples[4] = in_data.sample_4;
  assign samples[5] = in_data.sample_5;
  assign samples[6] = in_data.sample_6;
  assign samples[7] = in_data.sample_7;

  // One lane per channel; only active channels accumulate.
  for (genvar i = 0; i < ados_pkg::CHANNELS; i++) begin : g_lane
    assign lane_ctrl[i].acc_en    = acc_fire && (ados_pkg::NCH_W'(i) < nch);
    assign lane_ctrl[i].load      = (osc_r == '0);
    assign lane_ctrl[i].div_start = (state_r == ST_LOAD);
    assign lane_ctrl[i].div_step  = (state_r == ST_RUN);

    ados_lane u_lane (
      .clk      (clk),
      .ctrl     (lane_ctrl[i]),
      .sample   (samples[i]),
      .divisor  (divisor),
      .quotient (quot[i])
    );
  end

  assign emit.start = (state_r == ST_EMIT);
  assign emit.nch   = emit_nch_r;
  assign emit.pos   = emit_pos_r;
  assign emit.done  = emit_done_r;

  ados_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .quot      (quot),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .busy      (merge_busy)
  );

  // The merge stage must have drained before a new run is handed to it.
  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit.start |-> !merge_busy)
    else $error("merge stage started while still busy");

  // No item is taken while lane quotients are still being read out.
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !merge_busy && (state_r == ST_IDLE))
    else $error("input transfer during readout");

  // The flagged last result carries the highest active channel.
  a_last_channel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_of_run)
      |-> (out_data.channel_index == ados_pkg::CH_W'(emit_nch_r - 1'b1)))
    else $error("last_of_run on wrong channel");

  // Output register empties out of reset.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule
